// ===== rtl/core/text_console_cursor_engine_top_defines.svh =====
// ---------------------------------------------------------------------------
// Text console cursor engine - assertion macros
// Shared concurrent assertion forms used by the top level.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define TCCE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCCE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tcce_pkg.sv =====
// ---------------------------------------------------------------------------
// Text console cursor engine - package
// Types, codes and constants shared by the cursor engine modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcce_pkg;

    // renderer commands
    typedef enum logic [1:0] {
        CMD_DRAW        = 2'd0,
        CMD_SCROLL_UP   = 2'd1,
        CMD_SCROLL_DOWN = 2'd2,
        CMD_CLEAR       = 2'd3
    } cmd_t;

    // character codes
    localparam logic [7:0] CODE_LEFT      = 8'd8;
    localparam logic [7:0] CODE_RIGHT     = 8'd9;
    localparam logic [7:0] CODE_DOWN      = 8'd10;
    localparam logic [7:0] CODE_UP        = 8'd11;
    localparam logic [7:0] CODE_CLEAR     = 8'd12;
    localparam logic [7:0] CODE_CR        = 8'd13;
    localparam logic [7:0] CODE_PRINT_LO  = 8'd32;
    localparam logic [7:0] CODE_PRINT_HI  = 8'd127;

    // rows below the text area
    localparam logic [7:0] ROWS_RESERVED  = 8'd4;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W   = 2;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_ROWS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOUR       = 2'd2;

    // reset values
    localparam logic [7:0]  COLUMNS_RESET  = 8'd80;
    localparam logic [7:0]  ROWS_RESET     = 8'd33;
    localparam logic [15:0] COLOUR_DEFAULT = 16'h0F09;

    // stream widths
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 40;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    typedef struct packed {
        logic                   en;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_code;
        logic [7:0] set_col;
        logic [7:0] set_row;
    } req_t;

    typedef struct packed {
        cmd_t        command;
        logic [7:0]  cell_col;
        logic [7:0]  cell_row;
        logic [6:0]  glyph_index;
        logic [15:0] colours;
        logic        last;
    } result_t;

    // commands produced by one transaction
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_t;

endpackage

// ===== rtl/core/tcce_cursor.sv =====
// ---------------------------------------------------------------------------
// Text console cursor engine - cursor unit
// Holds the cursor and configuration registers and decodes each request
// into the next cursor position and up to two renderer commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcce_cursor (
    input  logic            aclk,
    input  logic            aresetn,
    input  tcce_pkg::cfg_wr_t cfg,
    input  logic            accept,
    input  tcce_pkg::req_t  req,
    output tcce_pkg::step_t step
);
    import tcce_pkg::*;

    logic [7:0]  col_reg, col_next;
    logic [7:0]  row_reg, row_next;
    logic [7:0]  cols_reg, cols_next;
    logic [7:0]  rows_reg, rows_next;
    logic [15:0] colour_reg, colour_next;

    logic [7:0] last_col, bottom_row;
    logic [7:0] right_col, right_row, down_row, up_row;
    logic       right_scroll, down_scroll, up_scroll;
    logic       draw, cmd_valid;
    cmd_t       cmd;
    result_t    draw_item, cmd_item;

    always_comb begin
        last_col    = (cols_reg == 8'd0) ? 8'd0 : cols_reg - 8'd1;
        bottom_row  = (rows_reg < ROWS_RESERVED) ? 8'd0 : rows_reg - ROWS_RESERVED;

        down_scroll = row_reg >= bottom_row;
        down_row    = down_scroll ? bottom_row : row_reg + 8'd1;
        up_scroll   = row_reg == 8'd0;
        up_row      = up_scroll ? row_reg : row_reg - 8'd1;

        right_col    = (col_reg >= last_col) ? 8'd0 : col_reg + 8'd1;
        right_row    = (col_reg >= last_col) ? down_row : row_reg;
        right_scroll = (col_reg >= last_col) && down_scroll;
    end

    always_comb begin
        col_next    = col_reg;
        row_next    = row_reg;
        cols_next   = cols_reg;
        rows_next   = rows_reg;
        colour_next = colour_reg;
        draw        = 1'b0;
        cmd_valid   = 1'b0;
        cmd         = CMD_CLEAR;

        if (cfg.en) begin
            unique case (cfg.index)
                CFG_TEXT_COLUMNS: cols_next   = cfg.data[7:0];
                CFG_TEXT_ROWS:    rows_next   = cfg.data[7:0];
                CFG_COLOUR:       colour_next = cfg.data;
                default: ;
            endcase
        end

        if (accept) begin
            if (req.req_type) begin
                col_next = (req.set_col > last_col)   ? last_col   : req.set_col;
                row_next = (req.set_row > bottom_row) ? bottom_row : req.set_row;
            end else begin
                case (req.char_code)
                    CODE_LEFT: begin
                        if (col_reg == 8'd0) begin
                            col_next  = last_col;
                            row_next  = up_row;
                            cmd_valid = up_scroll;
                            cmd       = CMD_SCROLL_DOWN;
                        end else begin
                            col_next  = col_reg - 8'd1;
                        end
                    end
                    CODE_RIGHT: begin
                        col_next  = right_col;
                        row_next  = right_row;
                        cmd_valid = right_scroll;
                        cmd       = CMD_SCROLL_UP;
                    end
                    CODE_DOWN: begin
                        row_next  = down_row;
                        cmd_valid = down_scroll;
                        cmd       = CMD_SCROLL_UP;
                    end
                    CODE_UP: begin
                        row_next  = up_row;
                        cmd_valid = up_scroll;
                        cmd       = CMD_SCROLL_DOWN;
                    end
                    CODE_CLEAR: begin
                        col_next    = 8'd0;
                        row_next    = 8'd0;
                        colour_next = COLOUR_DEFAULT;
                        cmd_valid   = 1'b1;
                        cmd         = CMD_CLEAR;
                    end
                    CODE_CR: begin
                        col_next = 8'd0;
                    end
                    default: begin
                        draw      = (req.char_code >= CODE_PRINT_LO) &&
                                    (req.char_code <= CODE_PRINT_HI);
                        col_next  = right_col;
                        row_next  = right_row;
                        cmd_valid = right_scroll;
                        cmd       = CMD_SCROLL_UP;
                    end
                endcase
            end
        end
    end

    always_comb begin
        draw_item.command     = CMD_DRAW;
        draw_item.cell_col    = col_reg;
        draw_item.cell_row    = row_reg;
        draw_item.glyph_index = 7'(req.char_code - CODE_PRINT_LO);
        draw_item.colours     = colour_reg;
        draw_item.last        = !cmd_valid;

        cmd_item.command      = cmd;
        cmd_item.cell_col     = 8'd0;
        cmd_item.cell_row     = 8'd0;
        cmd_item.glyph_index  = 7'd0;
        cmd_item.colours      = 16'd0;
        cmd_item.last         = 1'b1;

        step.count  = {1'b0, draw} + {1'b0, cmd_valid};
        step.first  = draw ? draw_item : cmd_item;
        step.second = cmd_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= 8'd0;
            row_reg    <= 8'd0;
            cols_reg   <= COLUMNS_RESET;
            rows_reg   <= ROWS_RESET;
            colour_reg <= COLOUR_DEFAULT;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            cols_reg   <= cols_next;
            rows_reg   <= rows_next;
            colour_reg <= colour_next;
        end
    end

endmodule

// ===== rtl/core/tcce_queue.sv =====
// ---------------------------------------------------------------------------
// Text console cursor engine - result queue
// Small register queue that takes up to two commands per cycle and
// presents one per cycle on the master side while pop_ready is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcce_queue #(
    parameter int unsigned DEPTH = tcce_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tcce_pkg::step_t   push,
    input  logic              pop_ready,
    output logic              room,
    output logic              head_valid,
    output tcce_pkg::result_t head
);
    import tcce_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);
    localparam logic [AW-1:0] LAST_PTR   = AW'(DEPTH - 1);

    result_t         mem [DEPTH];
    logic [AW-1:0]   head_reg, head_next;
    logic [AW-1:0]   tail_reg, tail_next;
    logic [AW-1:0]   tail_plus1;
    logic [CW-1:0]   count_reg, count_next;
    logic            pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + AW'(1);
    endfunction

    always_comb begin
        pop        = pop_ready && (count_reg != '0);
        tail_plus1 = ptr_inc(tail_reg);
        head_next  = pop ? ptr_inc(head_reg) : head_reg;
        case (push.count)
            2'd1:    tail_next = tail_plus1;
            2'd2:    tail_next = ptr_inc(tail_plus1);
            default: tail_next = tail_reg;
        endcase
        count_next = count_reg + CW'(push.count) - CW'(pop);
        room       = count_reg <= ROOM_LIMIT;
        head_valid = count_reg != '0;
        head       = mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[tail_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[tail_plus1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/text_console_cursor_engine_top.sv =====
// ---------------------------------------------------------------------------
// Text console cursor engine - top level
// Character-cell console cursor control producing renderer commands.
// ---------------------------------------------------------------------------
// Slave stream: one transaction per request. s_tuser is the request type
// (put character / set position), s_tdata carries the character byte and
// the set-position column and row. Master stream: renderer commands (draw,
// scroll up, scroll down, clear); m_tlast marks the last command caused by
// a request. A set-position request and most control codes produce no
// command; a printable character that wraps past the bottom row produces
// two.
// A command is written into the result queue when its request is taken and
// offered once the commands ahead of it have left. Throughput: one request
// per cycle while s_tready is high; the cursor update is a single pass
// through compare/increment logic between the cursor registers and the
// result queue, and s_tready drops once the queue cannot take two more.
// Reset (aresetn low, synchronous): cursor homed, registers to defaults,
// queue emptied. A stalled master holds its command; the slave side keeps
// accepting until the queue is near full.
// Configuration registers are written through cfg_wr_en; the user must do so while idle, the block does not enforce it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_cursor_engine_top_defines.svh"

module text_console_cursor_engine_top #(
    parameter int unsigned QUEUE_DEPTH = tcce_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [tcce_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // slave stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tcce_pkg::S_TDATA_W-1:0]      s_tdata,  // char_code, set_col, set_row
    input  logic                                s_tuser,  // req_type
    // master stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tcce_pkg::M_TDATA_W-1:0]      m_tdata,  // cell_col, cell_row, glyph_index,
                                                          // colours, zero pad
    output logic [1:0]                          m_tuser,  // command
    output logic                                m_tlast   // last
);
    import tcce_pkg::*;

    cfg_wr_t cfg;
    req_t    req;
    step_t   step;
    result_t head;
    logic    accept;
    logic    room;
    logic    head_valid;

    assign cfg.en    = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_wdata;

    assign req.req_type  = s_tuser;
    assign req.char_code = s_tdata[7:0];
    assign req.set_col   = s_tdata[15:8];
    assign req.set_row   = s_tdata[23:16];

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    tcce_cursor u_cursor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .accept  (accept),
        .req     (req),
        .step    (step)
    );

    tcce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (step),
        .pop_ready  (m_tready),
        .room       (room),
        .head_valid (head_valid),
        .head       (head)
    );

    assign m_tvalid = head_valid;
    assign m_tuser  = head.command;
    assign m_tlast  = head.last;
    assign m_tdata  = {1'b0, head.colours, head.glyph_index, head.cell_row, head.cell_col};

    `TCCE_ASSERT_NXT(a_push_shows, aclk, aresetn, step.count != 2'd0, m_tvalid,
        "command pushed but not offered")

    `TCCE_ASSERT_IMP(a_pair_order, aclk, aresetn, step.count == 2'd2,
        step.first.command == CMD_DRAW && step.second.command == CMD_SCROLL_UP,
        "two-command transaction not draw then scroll up")

    `TCCE_ASSERT_IMP(a_idle_quiet, aclk, aresetn, !accept, step.count == 2'd0,
        "commands produced without a transaction")

endmodule

// ===== bench/tb_text_console_cursor_engine_top.sv =====
// ---------------------------------------------------------------------------
// Text console cursor engine - testbench
// Streams character and set-position requests into the cursor engine across
// several console geometries and colour settings. Every renderer command is
// checked field by field against a cursor model held in the bench, or against
// the command a typed directed row carries. Both stream sides idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_console_cursor_engine_top;

    import tcce_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned SETTLE_TICKS = 4;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned ITEMS_PHASE  = 85;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_code;
        logic [7:0] set_col;
        logic [7:0] set_row;
        logic       typed;
        result_t    cmd;
    } stim_row_t;

    // Typed rows carry their command; the rest go through the cursor model.
    localparam stim_row_t DIRECTED [23] = '{
        '{1'b0, 8'd65,         8'd0,   8'd0,   1'b1, '{CMD_DRAW, 8'd0, 8'd0, 7'd33,
                                                       COLOUR_DEFAULT, 1'b1}},
        '{1'b0, CODE_PRINT_HI, 8'd0,   8'd0,   1'b1, '{CMD_DRAW, 8'd1, 8'd0, 7'd95,
                                                       COLOUR_DEFAULT, 1'b1}},
        '{1'b0, CODE_PRINT_LO, 8'd0,   8'd0,   1'b1, '{CMD_DRAW, 8'd2, 8'd0, 7'd0,
                                                       COLOUR_DEFAULT, 1'b1}},
        '{1'b0, 8'd0,          8'd0,   8'd0,   1'b0, '0},
        '{1'b0, 8'd255,        8'd255, 8'd255, 1'b0, '0},
        '{1'b0, 8'd128,        8'd0,   8'd0,   1'b0, '0},
        '{1'b0, 8'd31,         8'd0,   8'd0,   1'b0, '0},
        '{1'b0, CODE_LEFT,     8'd0,   8'd0,   1'b0, '0},
        '{1'b0, CODE_RIGHT,    8'd0,   8'd0,   1'b0, '0},
        '{1'b0, CODE_DOWN,     8'd0,   8'd0,   1'b0, '0},
        '{1'b0, CODE_UP,       8'd0,   8'd0,   1'b0, '0},
        '{1'b0, CODE_CR,       8'd0,   8'd0,   1'b0, '0},
        '{1'b0, CODE_LEFT,     8'd0,   8'd0,   1'b1, '{CMD_SCROLL_DOWN, 8'd0, 8'd0, 7'd0,
                                                       16'h0000, 1'b1}},
        '{1'b0, CODE_UP,       8'd0,   8'd0,   1'b1, '{CMD_SCROLL_DOWN, 8'd0, 8'd0, 7'd0,
                                                       16'h0000, 1'b1}},
        '{1'b1, 8'd65,         8'd255, 8'd255, 1'b0, '0},
        '{1'b0, CODE_RIGHT,    8'd0,   8'd0,   1'b1, '{CMD_SCROLL_UP, 8'd0, 8'd0, 7'd0,
                                                       16'h0000, 1'b1}},
        '{1'b1, 8'd255,        8'd79,  8'd29,  1'b0, '0},
        '{1'b0, 8'd90,         8'd0,   8'd0,   1'b0, '0},
        '{1'b0, CODE_DOWN,     8'd0,   8'd0,   1'b1, '{CMD_SCROLL_UP, 8'd0, 8'd0, 7'd0,
                                                       16'h0000, 1'b1}},
        '{1'b0, 8'd65,         8'd0,   8'd0,   1'b1, '{CMD_DRAW, 8'd0, 8'd29, 7'd33,
                                                       COLOUR_DEFAULT, 1'b1}},
        '{1'b0, CODE_CLEAR,    8'd0,   8'd0,   1'b1, '{CMD_CLEAR, 8'd0, 8'd0, 7'd0,
                                                       16'h0000, 1'b1}},
        '{1'b1, 8'd0,          8'd3,   8'd4,   1'b0, '0},
        '{1'b0, 8'd126,        8'd0,   8'd0,   1'b0, '0}
    };

    localparam logic [7:0]  PHASE_COLS    [PHASES] = '{8'd255, 8'd1, 8'd0, 8'd7, 8'd40, 8'd80};
    localparam logic [7:0]  PHASE_ROWS    [PHASES] = '{8'd255, 8'd5, 8'd2, 8'd8, 8'd20, 8'd33};
    localparam logic [15:0] PHASE_COLOURS [PHASES] = '{16'hFFFF, 16'h0000, 16'h5AA5,
                                                       16'h0000, 16'h0000, COLOUR_DEFAULT};

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    // sideband for the transaction on the slave bus
    logic                 s_typed;
    result_t              s_typed_cmd;

    // cursor model
    logic [7:0]  cur_col;
    logic [7:0]  cur_row;
    logic [7:0]  reg_columns;
    logic [7:0]  reg_rows;
    logic [15:0] reg_colour;
    result_t     step_cmds [$];
    result_t     pending_cmds [$];
    result_t     want_cmd;

    int unsigned bad_fields  = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    int unsigned ready_ticks = 0;
    int unsigned ready_mode  = 0;

    text_console_cursor_engine_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] last_column();
        return (reg_columns == 8'd0) ? 8'd0 : reg_columns - 8'd1;
    endfunction

    function automatic logic [7:0] bottom_text_row();
        return (reg_rows < ROWS_RESERVED) ? 8'd0 : reg_rows - ROWS_RESERVED;
    endfunction

    function automatic void note_cmd(cmd_t c, logic [7:0] col, logic [7:0] row,
                                     logic [6:0] glyph, logic [15:0] colr);
        result_t r;
        r.command     = c;
        r.cell_col    = col;
        r.cell_row    = row;
        r.glyph_index = glyph;
        r.colours     = colr;
        r.last        = 1'b0;
        step_cmds.push_back(r);
    endfunction

    function automatic void cursor_down();
        if (cur_row >= bottom_text_row()) begin
            cur_row = bottom_text_row();
            note_cmd(CMD_SCROLL_UP, 8'd0, 8'd0, 7'd0, 16'd0);
        end else begin
            cur_row = cur_row + 8'd1;
        end
    endfunction

    function automatic void cursor_up();
        if (cur_row == 8'd0) begin
            note_cmd(CMD_SCROLL_DOWN, 8'd0, 8'd0, 7'd0, 16'd0);
        end else begin
            cur_row = cur_row - 8'd1;
        end
    endfunction

    function automatic void cursor_right();
        if (cur_col >= last_column()) begin
            cur_col = 8'd0;
            cursor_down();
        end else begin
            cur_col = cur_col + 8'd1;
        end
    endfunction

    // renderer commands for one request, left in step_cmds
    function automatic void console_step(req_t r);
        step_cmds.delete();
        if (r.req_type) begin
            cur_col = (r.set_col > last_column()) ? last_column() : r.set_col;
            cur_row = (r.set_row > bottom_text_row()) ? bottom_text_row() : r.set_row;
        end else begin
            case (r.char_code)
                CODE_LEFT: begin
                    if (cur_col == 8'd0) begin
                        cur_col = last_column();
                        cursor_up();
                    end else begin
                        cur_col = cur_col - 8'd1;
                    end
                end
                CODE_RIGHT: cursor_right();
                CODE_DOWN:  cursor_down();
                CODE_UP:    cursor_up();
                CODE_CLEAR: begin
                    cur_col    = 8'd0;
                    cur_row    = 8'd0;
                    reg_colour = COLOUR_DEFAULT;
                    note_cmd(CMD_CLEAR, 8'd0, 8'd0, 7'd0, 16'd0);
                end
                CODE_CR:    cur_col = 8'd0;
                default: begin
                    if (r.char_code >= CODE_PRINT_LO && r.char_code <= CODE_PRINT_HI) begin
                        note_cmd(CMD_DRAW, cur_col, cur_row, 7'(r.char_code - CODE_PRINT_LO),
                                 reg_colour);
                    end
                    cursor_right();
                end
            endcase
        end
        if (step_cmds.size() > 0) begin
            step_cmds[step_cmds.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic req_t make_req(logic req_type, logic [7:0] code,
                                      logic [7:0] col, logic [7:0] row);
        req_t r;
        r.req_type  = req_type;
        r.char_code = code;
        r.set_col   = col;
        r.set_row   = row;
        return r;
    endfunction

    function automatic req_t random_req();
        req_t        r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        r    = make_req(pick < 12, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
        if (pick >= 12 && pick < 55) begin
            r.char_code = 8'($urandom_range(CODE_PRINT_LO, CODE_PRINT_HI));
        end else if (pick >= 55 && pick < 85) begin
            r.char_code = 8'($urandom_range(CODE_LEFT, CODE_CR));
        end
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            bad_fields++;
        end
    endfunction

    // model update on accepted configuration writes and requests
    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_col     = 8'd0;
            cur_row     = 8'd0;
            reg_columns = COLUMNS_RESET;
            reg_rows    = ROWS_RESET;
            reg_colour  = COLOUR_DEFAULT;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_TEXT_COLUMNS: reg_columns = cfg_wdata[7:0];
                    CFG_TEXT_ROWS:    reg_rows    = cfg_wdata[7:0];
                    CFG_COLOUR:       reg_colour  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                console_step(make_req(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]));
                if (s_typed) begin
                    pending_cmds.push_back(s_typed_cmd);
                end else begin
                    foreach (step_cmds[i]) pending_cmds.push_back(step_cmds[i]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cmds.size() == 0) begin
                $error("command %0d arrived with nothing expected", m_tuser);
                bad_fields++;
            end else begin
                want_cmd = pending_cmds.pop_front();
                check_field("command",     want_cmd.command,     m_tuser);
                check_field("cell_col",    want_cmd.cell_col,    m_tdata[7:0]);
                check_field("cell_row",    want_cmd.cell_row,    m_tdata[15:8]);
                check_field("glyph_index", want_cmd.glyph_index, m_tdata[22:16]);
                check_field("colours",     want_cmd.colours,     m_tdata[38:23]);
                check_field("last",        want_cmd.last,        m_tlast);
            end
        end
    end

    // receiver: stall mode is redrawn at random whenever its tick counter runs out
    always @(posedge aclk) begin
        if (ready_ticks == 0) begin
            ready_mode  <= $urandom_range(0, 3);
            ready_ticks <= 50;
        end else begin
            ready_ticks <= ready_ticks - 1;
        end
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (ready_ticks[1:0] != 2'd0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic drive_req(input req_t r, input logic typed, input result_t cmd);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
        end
        s_tvalid    <= 1'b1;
        s_tuser     <= r.req_type;
        s_tdata     <= {r.set_row, r.set_col, r.char_code};
        s_typed     <= typed;
        s_typed_cmd <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // hold off until every command is out, then let the pipe empty
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_cmds.size() != 0);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic load_settings(input logic [7:0] cols, input logic [7:0] rows,
                                 input logic [15:0] colr);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TEXT_COLUMNS;
        cfg_wdata <= {8'h00, cols};
        @(posedge aclk);
        cfg_index <= CFG_TEXT_ROWS;
        cfg_wdata <= {8'h00, rows};
        @(posedge aclk);
        cfg_index <= CFG_COLOUR;
        cfg_wdata <= colr;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [15:0] colr;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_TEXT_COLUMNS;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        s_typed     = 1'b0;
        s_typed_cmd = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            drive_req(make_req(DIRECTED[i].req_type, DIRECTED[i].char_code,
                               DIRECTED[i].set_col, DIRECTED[i].set_row),
                      DIRECTED[i].typed, DIRECTED[i].cmd);
        end
        // park the cursor as far out as the area allows
        drive_req(make_req(1'b1, 8'd0, 8'd255, 8'd255), 1'b0, '0);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            colr = (p == 3 || p == 4) ? 16'($urandom) : PHASE_COLOURS[p];
            load_settings(PHASE_COLS[p], PHASE_ROWS[p], colr);
            // cursor may now sit outside a shrunken area
            drive_req(make_req(1'b0, CODE_DOWN, 8'd0, 8'd0), 1'b0, '0);
            drive_req(make_req(1'b0, CODE_RIGHT, 8'd0, 8'd0), 1'b0, '0);
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                drive_req(random_req(), 1'b0, '0);
            end
            drive_req(make_req(1'b1, 8'($urandom_range(0, 255)), 8'd255, 8'd255), 1'b0, '0);
        end
        settle();

        if (bad_fields == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tcce_pkg.sv
rtl/core/tcce_cursor.sv
rtl/core/tcce_queue.sv
rtl/core/text_console_cursor_engine_top.sv
bench/tb_text_console_cursor_engine_top.sv
